/* rtl/json_string_unescaper_top_defines.svh */
// Assertion macros shared by the JSON string unescaper RTL.
// Included by json_string_unescaper_top.sv; no other dependencies.
`ifndef JSON_STRING_UNESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define JSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsu assertion failed");
// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jsu assertion failed");
`else
`define JSU_ASSERT(lbl, clk, rst_n, prop)
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* rtl/jsu_pkg.sv */
// Types, codes and helper functions for the JSON string unescaper.
// Used by jsu_decoder and json_string_unescaper_top; no dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_NO_OPEN_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_END_AFTER_ESC  = 3'd1;
    localparam logic [2:0] ERR_END_IN_UNICODE = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX        = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_ESC    = 3'd4;
    localparam logic [2:0] ERR_END_IN_BODY    = 3'd5;

    // Decoder state carried from one transaction to the next.
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_count;
        logic [15:0] code_point;
        logic        bad_hex;
    } dec_state_t;

    // All results caused by one input transaction.
    typedef struct packed {
        logic [1:0] cnt;
        kind_t      kind;
        logic [2:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       fin;
    } res_grp_t;

    // Returns {valid, value}; an invalid digit yields value zero.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

/* rtl/json_string_unescaper_top.sv */
// A byte is held in the input register; its results leave from the result register.
// Throughput: one byte per cycle while m_tready is high; a \uXXXX escape that yields
// two or three UTF-8 bytes holds the result register until all are sent, one result
// per cycle while m_tready is high. Reset (aresetn low, synchronous) empties both
// registers and returns the decoder to idle, awaiting a byte flagged first.
// Depends on jsu_pkg, jsu_decoder and json_string_unescaper_top_defines.svh.
`include "json_string_unescaper_top_defines.svh"

module json_string_unescaper_top import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_first_reg, in_first_next;
    dec_state_t state_reg, state_next, dec_state;
    res_grp_t   grp_reg, grp_next, dec_grp;
    logic       grp_valid_reg, grp_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] grp_last_idx;
    logic       grp_free;
    logic       advance;
    logic [7:0] cur_byte;

    jsu_decoder u_decoder (
        .in_byte   (in_byte_reg),
        .first     (in_first_reg),
        .state_in  (state_reg),
        .state_out (dec_state),
        .grp       (dec_grp)
    );

    assign grp_last_idx = grp_reg.cnt - 2'd1;
    // The result register may take a new group once its last result goes out.
    assign grp_free     = !grp_valid_reg || (m_tready && idx_reg == grp_last_idx);
    assign advance      = in_valid_reg && (dec_grp.cnt == 2'd0 || grp_free);
    assign s_tready     = !in_valid_reg || advance;

    always_comb begin
        case (idx_reg)
            2'd0:    cur_byte = grp_reg.b0;
            2'd1:    cur_byte = grp_reg.b1;
            2'd2:    cur_byte = grp_reg.b2;
            default: cur_byte = 8'd0;
        endcase
    end

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = {5'd0, grp_reg.err, cur_byte};
    assign m_tuser  = grp_reg.kind;
    assign m_tlast  = grp_reg.fin && (idx_reg == grp_last_idx);

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_first_next  = in_first_reg;
        state_next     = state_reg;
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;

        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
            in_first_next = s_tuser;
        end

        if (advance) begin
            state_next = dec_state;
        end

        if (grp_valid_reg && m_tready) begin
            if (idx_reg == grp_last_idx) begin
                grp_valid_next = 1'b0;
                idx_next       = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end

        if (advance && dec_grp.cnt != 2'd0) begin
            grp_valid_next = 1'b1;
            grp_next       = dec_grp;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, hex_count: 2'd0, code_point: 16'd0,
                               bad_hex: 1'b0};
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        in_first_reg <= in_first_next;
        grp_reg      <= grp_next;
    end

    `JSU_ASSERT(a_idx_in_group, aclk, aresetn, grp_valid_reg |-> (idx_reg < grp_reg.cnt))
    `JSU_ASSERT(a_error_single, aclk, aresetn, (grp_valid_reg && grp_reg.kind == KIND_ERROR) |-> (grp_reg.cnt == 2'd1 && !grp_reg.fin))
    `JSU_ASSERT(a_three_byte_lead, aclk, aresetn, (grp_valid_reg && grp_reg.cnt == 2'd3) |-> (grp_reg.b0[7:4] == 4'hE))
    `JSU_ASSERT_NEXT(a_held_input, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))
    `JSU_ASSERT(a_done_single, aclk, aresetn, (grp_valid_reg && grp_reg.kind == KIND_DONE) |-> (grp_reg.cnt == 2'd1 && grp_reg.fin))

endmodule

/* rtl/jsu_decoder.sv */
// Combinational decode of one byte: next decoder state and its result group.
// Depends on jsu_pkg.
module jsu_decoder import jsu_pkg::*; (
    input  logic [7:0] in_byte,
    input  logic       first,
    input  dec_state_t state_in,
    output dec_state_t state_out,
    output res_grp_t   grp
);

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    logic [4:0]  hv;
    logic [15:0] cp;
    logic        bad;

    always_comb begin
        state_out = state_in;
        grp       = '0;
        grp.kind  = KIND_BYTE;
        hv        = hex_nibble(in_byte);
        cp        = {state_in.code_point[11:0], hv[3:0]};
        bad       = state_in.bad_hex | ~hv[4];

        if (first) begin
            if (in_byte != CH_QUOTE) begin
                state_out.phase = PH_IDLE;
                grp.cnt  = 2'd1;
                grp.kind = KIND_ERROR;
                grp.err  = ERR_NO_OPEN_QUOTE;
            end else begin
                state_out.phase = PH_BODY;
            end
        end else begin
            case (state_in.phase)
                PH_BODY: begin
                    if (in_byte == CH_NUL) begin
                        state_out.phase = PH_IDLE;
                        grp.cnt  = 2'd1;
                        grp.kind = KIND_ERROR;
                        grp.err  = ERR_END_IN_BODY;
                    end else if (in_byte == CH_QUOTE) begin
                        state_out.phase = PH_IDLE;
                        grp.cnt  = 2'd1;
                        grp.kind = KIND_DONE;
                        grp.fin  = 1'b1;
                    end else if (in_byte == CH_BACKSLASH) begin
                        state_out.phase = PH_ESC;
                    end else begin
                        grp.cnt = 2'd1;
                        grp.b0  = in_byte;
                        grp.fin = 1'b1;
                    end
                end
                PH_ESC: begin
                    state_out.phase = PH_BODY;
                    grp.cnt = 2'd1;
                    grp.fin = 1'b1;
                    case (in_byte)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: grp.b0 = in_byte;
                        CH_B: grp.b0 = 8'h08;
                        CH_F: grp.b0 = 8'h0C;
                        CH_N: grp.b0 = 8'h0A;
                        CH_R: grp.b0 = 8'h0D;
                        CH_T: grp.b0 = 8'h09;
                        CH_U: begin
                            state_out.phase      = PH_HEX;
                            state_out.hex_count  = 2'd0;
                            state_out.code_point = 16'd0;
                            state_out.bad_hex    = 1'b0;
                            grp.cnt = 2'd0;
                            grp.fin = 1'b0;
                        end
                        CH_NUL: begin
                            state_out.phase = PH_IDLE;
                            grp.kind = KIND_ERROR;
                            grp.err  = ERR_END_AFTER_ESC;
                            grp.fin  = 1'b0;
                        end
                        default: begin
                            state_out.phase = PH_IDLE;
                            grp.kind = KIND_ERROR;
                            grp.err  = ERR_UNKNOWN_ESC;
                            grp.fin  = 1'b0;
                        end
                    endcase
                end
                PH_HEX: begin
                    if (in_byte == CH_NUL) begin
                        // End of input among the digits wins over any bad digit.
                        state_out.phase = PH_IDLE;
                        grp.cnt  = 2'd1;
                        grp.kind = KIND_ERROR;
                        grp.err  = ERR_END_IN_UNICODE;
                    end else begin
                        state_out.code_point = cp;
                        state_out.bad_hex    = bad;
                        if (state_in.hex_count != 2'd3) begin
                            state_out.hex_count = state_in.hex_count + 2'd1;
                        end else begin
                            state_out.hex_count = 2'd0;
                            if (bad) begin
                                state_out.phase = PH_IDLE;
                                grp.cnt  = 2'd1;
                                grp.kind = KIND_ERROR;
                                grp.err  = ERR_BAD_HEX;
                            end else begin
                                state_out.phase = PH_BODY;
                                grp.fin = 1'b1;
                                if (cp <= 16'h007F) begin
                                    grp.cnt = 2'd1;
                                    grp.b0  = cp[7:0];
                                end else if (cp <= 16'h07FF) begin
                                    grp.cnt = 2'd2;
                                    grp.b0  = 8'hC0 | {3'b000, cp[10:6]};
                                    grp.b1  = 8'h80 | {2'b00, cp[5:0]};
                                end else begin
                                    grp.cnt = 2'd3;
                                    grp.b0  = 8'hE0 | {4'b0000, cp[15:12]};
                                    grp.b1  = 8'h80 | {2'b00, cp[11:6]};
                                    grp.b2  = 8'h80 | {2'b00, cp[5:0]};
                                end
                            end
                        end
                    end
                end
                default: begin
                    state_out.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule
